// ===== rtl/core/rkc_pkg.sv =====
// ----------------------------------------------------------------------------
// rkc_pkg
// Shared types and constants of the RGB 3x3 kernel convolution core.
// ----------------------------------------------------------------------------
package rkc_pkg;

  localparam int KERNEL_SIZE   = 3;
  localparam int KERNEL_TAPS   = KERNEL_SIZE * KERNEL_SIZE;
  localparam int LINES         = KERNEL_SIZE - 1;
  localparam int COEF_BITS     = 8;
  localparam int CHAN_BITS     = 8;
  localparam int NUM_CHAN      = 3;
  localparam int PIX_BITS      = NUM_CHAN * CHAN_BITS;
  localparam int ROW_BITS      = KERNEL_SIZE * COEF_BITS;
  localparam int DEF_MAX_WIDTH = 2048;

  // register file layout
  localparam int CFG_DATA_BITS = 24;
  localparam int CFG_IDX_BITS  = 3;
  localparam int DIV_BITS      = 11;
  localparam int FW_BITS       = 12;
  localparam int OCOL_BITS     = 11;

  // filter arithmetic widths
  localparam int PROD_BITS = COEF_BITS + CHAN_BITS + 1;
  localparam int SUM_BITS  = 20;
  localparam int QUO_BITS  = SUM_BITS - 1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_KERNEL_TOP    = 3'd0,
    REG_KERNEL_MIDDLE = 3'd1,
    REG_KERNEL_BOTTOM = 3'd2,
    REG_DIVISOR       = 3'd3,
    REG_FRAME_WIDTH   = 3'd4
  } cfg_reg_t;

  localparam logic [ROW_BITS-1:0] KERNEL_TOP_RST    = ROW_BITS'(0);
  localparam logic [ROW_BITS-1:0] KERNEL_MIDDLE_RST = ROW_BITS'(256);
  localparam logic [ROW_BITS-1:0] KERNEL_BOTTOM_RST = ROW_BITS'(0);
  localparam logic [DIV_BITS-1:0] DIVISOR_RST       = DIV_BITS'(1);
  localparam logic [FW_BITS-1:0]  FRAME_WIDTH_RST   = FW_BITS'(2048);

  // lane status seen by the control sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } lane_status_t;

endpackage

// ===== rtl/core/rkc_if.sv =====
// ----------------------------------------------------------------------------
// rkc_if
// Valid/ready stream interfaces for pixel input and filtered result output.
// ----------------------------------------------------------------------------
interface rkc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic       frame_start;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  output frame_start, input ready);
  modport sink (input valid, input red_in, input green_in, input blue_in,
                input frame_start, output ready);
endinterface

interface rkc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  red_out;
  logic [7:0]  green_out;
  logic [7:0]  blue_out;
  logic [10:0] out_column;
  logic        row_end;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output out_column, output row_end, input ready);
  modport sink (input valid, input red_out, input green_out, input blue_out,
                input out_column, input row_end, output ready);
endinterface

// ===== rtl/core/rgb_kernel_convolution_core.sv =====
// ----------------------------------------------------------------------------
// rgb_kernel_convolution_core
// Streaming normalized 3x3 convolution of RGB pixels with two line stores.
// ----------------------------------------------------------------------------
// An accepted pixel shifts the window; if it makes a result, the channel lanes
//   then multiply, sum and divide in their bit-serial divider, which a negative
//   sum skips. A new pixel is accepted only once the last one is through,
//   including any output stall.
// Reset: synchronous active-low rst_n clears control, counters, window and
//   configuration registers; line store contents stay undefined until written.
module rgb_kernel_convolution_core #(
  parameter int MAX_WIDTH = rkc_pkg::DEF_MAX_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  rkc_in_if.sink                             in_pix,
  rkc_out_if.source                          out_pix,
  input  logic                               cfg_we,
  input  logic [rkc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [rkc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import rkc_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int EW = (WW > FW_BITS) ? WW : FW_BITS;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SHIFT = 4'b0010,
    S_START = 4'b0100,
    S_WAIT  = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [ROW_BITS-1:0] kern_r [KERNEL_SIZE];
  logic [DIV_BITS-1:0] divisor_r;
  logic [FW_BITS-1:0]  frame_width_r;
  logic [PIX_BITS-1:0] win_r [KERNEL_SIZE][KERNEL_SIZE];
  logic [AW-1:0]       column_count_r;
  logic [1:0]          rows_seen_r;
  logic [PIX_BITS-1:0] pix_r;
  logic [AW-1:0]       col_r;
  logic                emit_r;
  logic                row_end_r;
  logic [EW-1:0]       width_eff;
  logic [EW-1:0]       fw_ext;
  logic [AW-1:0]       col;
  logic [1:0]          rows_eff;
  logic [EW-1:0]       col_inc;
  logic                in_accept;
  logic [PIX_BITS-1:0] line_rd [LINES];

  logic [CHAN_BITS-1:0]        lane_pix  [NUM_CHAN][KERNEL_TAPS];
  logic signed [COEF_BITS-1:0] lane_coef [KERNEL_TAPS];
  logic [CHAN_BITS-1:0]        lane_res  [NUM_CHAN];
  lane_status_t                lane_st   [NUM_CHAN];
  logic                        lanes_done;

  logic                 out_valid_r;
  logic [CHAN_BITS-1:0] out_chan_r [NUM_CHAN];
  logic [OCOL_BITS-1:0] out_col_r;
  logic                 out_row_end_r;
  logic                 out_load;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kern_r[0]     <= KERNEL_TOP_RST;
      kern_r[1]     <= KERNEL_MIDDLE_RST;
      kern_r[2]     <= KERNEL_BOTTOM_RST;
      divisor_r     <= DIVISOR_RST;
      frame_width_r <= FRAME_WIDTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KERNEL_TOP:    kern_r[0]     <= cfg_data[ROW_BITS-1:0];
        REG_KERNEL_MIDDLE: kern_r[1]     <= cfg_data[ROW_BITS-1:0];
        REG_KERNEL_BOTTOM: kern_r[2]     <= cfg_data[ROW_BITS-1:0];
        REG_DIVISOR:       divisor_r     <= cfg_data[DIV_BITS-1:0];
        REG_FRAME_WIDTH:   frame_width_r <= cfg_data[FW_BITS-1:0];
        default: ;
      endcase
    end
  end

  // clamp frame width to 3..MAX_WIDTH
  assign fw_ext = EW'(frame_width_r);
  always_comb begin
    priority if (fw_ext < EW'(KERNEL_SIZE)) begin
      width_eff = EW'(KERNEL_SIZE);
    end else if (fw_ext > EW'(MAX_WIDTH)) begin
      width_eff = EW'(MAX_WIDTH);
    end else begin
      width_eff = fw_ext;
    end
  end

  // column and row position of the incoming pixel
  always_comb begin
    rows_eff = in_pix.frame_start ? 2'd0 : rows_seen_r;
    if (in_pix.frame_start || EW'(column_count_r) >= width_eff) begin
      col = '0;
    end else begin
      col = column_count_r;
    end
    col_inc = EW'(col) + EW'(1);
  end

  assign in_accept    = in_pix.valid && in_pix.ready;
  assign in_pix.ready = (state_r == S_IDLE);

  // position counters and per-transaction context
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r <= '0;
      rows_seen_r    <= '0;
      emit_r         <= 1'b0;
    end else if (in_accept) begin
      emit_r <= (rows_eff >= 2'(LINES)) && (EW'(col) >= EW'(LINES));
      if (col_inc >= width_eff) begin
        column_count_r <= '0;
        rows_seen_r    <= (rows_eff < 2'(LINES)) ? rows_eff + 2'd1 : rows_eff;
      end else begin
        column_count_r <= col_inc[AW-1:0];
        rows_seen_r    <= rows_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      pix_r     <= {in_pix.blue_in, in_pix.green_in, in_pix.red_in};
      col_r     <= col;
      row_end_r <= (col_inc == width_eff);
    end
  end

  // line stores: read at accept, shift down one line in the following cycle
  rkc_ram #(.WIDTH(PIX_BITS), .DEPTH(MAX_WIDTH)) u_line0 (
    .clk   (clk),
    .we    (state_r == S_SHIFT),
    .waddr (col_r),
    .wdata (line_rd[1]),
    .re    (in_accept),
    .raddr (col),
    .rdata (line_rd[0])
  );

  rkc_ram #(.WIDTH(PIX_BITS), .DEPTH(MAX_WIDTH)) u_line1 (
    .clk   (clk),
    .we    (state_r == S_SHIFT),
    .waddr (col_r),
    .wdata (pix_r),
    .re    (in_accept),
    .raddr (col),
    .rdata (line_rd[1])
  );

  // advance the window by one column
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < KERNEL_SIZE; r++) begin
        for (int c = 0; c < KERNEL_SIZE; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else if (state_r == S_SHIFT) begin
      for (int r = 0; r < KERNEL_SIZE; r++) begin
        for (int c = 0; c < KERNEL_SIZE - 1; c++) begin
          win_r[r][c] <= win_r[r][c+1];
        end
      end
      for (int r = 0; r < LINES; r++) begin
        win_r[r][KERNEL_SIZE-1] <= line_rd[r];
      end
      win_r[KERNEL_SIZE-1][KERNEL_SIZE-1] <= pix_r;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_accept) state_nxt = S_SHIFT;
      S_SHIFT: state_nxt = emit_r ? S_START : S_IDLE;
      S_START: state_nxt = S_WAIT;
      S_WAIT:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // lane operands
  always_comb begin
    for (int r = 0; r < KERNEL_SIZE; r++) begin
      for (int c = 0; c < KERNEL_SIZE; c++) begin
        lane_coef[r*KERNEL_SIZE+c] = $signed(kern_r[r][c*COEF_BITS +: COEF_BITS]);
        for (int ch = 0; ch < NUM_CHAN; ch++) begin
          lane_pix[ch][r*KERNEL_SIZE+c] = win_r[r][c][ch*CHAN_BITS +: CHAN_BITS];
        end
      end
    end
  end

  for (genvar ch = 0; ch < NUM_CHAN; ch++) begin : g_lane
    rkc_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .start   (state_r == S_START),
      .pix     (lane_pix[ch]),
      .coef    (lane_coef),
      .divisor (divisor_r),
      .result  (lane_res[ch]),
      .status  (lane_st[ch])
    );
  end

  // wait for every lane; a negative sum finishes early without dividing
  always_comb begin
    lanes_done = 1'b1;
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      lanes_done = lanes_done && lane_st[ch].done && !lane_st[ch].busy;
    end
  end

  // merge lane results into the output register
  assign out_load = (state_r == S_WAIT) && lanes_done
                    && (!out_valid_r || out_pix.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_pix.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
        out_chan_r[ch] <= lane_res[ch];
      end
      out_col_r     <= OCOL_BITS'(EW'(col_r) - EW'(LINES));
      out_row_end_r <= row_end_r;
    end
  end

  assign out_pix.valid      = out_valid_r;
  assign out_pix.red_out    = out_chan_r[0];
  assign out_pix.green_out  = out_chan_r[1];
  assign out_pix.blue_out   = out_chan_r[2];
  assign out_pix.out_column = out_col_r;
  assign out_pix.row_end    = out_row_end_r;

  // no lane works while the core waits for a pixel
  a_lanes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !(lane_st[0].busy || lane_st[1].busy || lane_st[2].busy))
    else $error("channel lane busy while idle");
  // every accepted transaction goes through the window shift
  a_accept_shift: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == S_SHIFT))
    else $error("accepted pixel skipped window shift");
  // a result is only produced for an in-frame window position
  a_emit_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (emit_r && EW'(col_r) >= EW'(LINES) && EW'(col_r) < width_eff))
    else $error("result for window outside the frame");
  // the column counter stays inside the active width
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> (EW'(col_r) < width_eff))
    else $error("column beyond frame width");

endmodule

// ===== rtl/core/rkc_ram.sv =====
// ----------------------------------------------------------------------------
// rkc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rkc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/rkc_lane.sv =====
// ----------------------------------------------------------------------------
// rkc_lane
// One color channel: 9-tap signed multiply-accumulate, bit-serial division by
// the divisor, clamp to 0..255.
// ----------------------------------------------------------------------------
module rkc_lane (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              start,
  input  logic [rkc_pkg::CHAN_BITS-1:0]                     pix [rkc_pkg::KERNEL_TAPS],
  input  logic signed [rkc_pkg::COEF_BITS-1:0]              coef [rkc_pkg::KERNEL_TAPS],
  input  logic [rkc_pkg::DIV_BITS-1:0]                      divisor,
  output logic [rkc_pkg::CHAN_BITS-1:0]                     result,
  output rkc_pkg::lane_status_t                             status
);
  import rkc_pkg::*;

  localparam int CNT_BITS = $clog2(QUO_BITS + 1);

  logic signed [PROD_BITS-1:0] prod_r [KERNEL_TAPS];
  logic signed [SUM_BITS-1:0]  sum_r;
  logic signed [SUM_BITS-1:0]  sum_nxt;
  logic                        prod_vld_r;
  logic                        sum_vld_r;
  logic                        div_busy_r;
  logic [CNT_BITS-1:0]         cnt_r;
  logic [QUO_BITS-1:0]         quo_r;
  logic [QUO_BITS-1:0]         quo_nxt;
  logic [DIV_BITS-1:0]         rem_r;
  logic [DIV_BITS-1:0]         rem_nxt;
  logic [DIV_BITS:0]           trial;
  logic [DIV_BITS:0]           dv;
  logic                        done_r;
  logic [CHAN_BITS-1:0]        result_r;

  // divisor zero acts as one
  assign dv = (divisor == '0) ? (DIV_BITS+1)'(1) : {1'b0, divisor};

  // add the registered products
  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < KERNEL_TAPS; i++) begin
      sum_nxt = sum_nxt + SUM_BITS'(prod_r[i]);
    end
  end

  // one restoring division step
  always_comb begin
    trial = {rem_r, quo_r[QUO_BITS-1]};
    if (trial >= dv) begin
      rem_nxt = DIV_BITS'(trial - dv);
      quo_nxt = {quo_r[QUO_BITS-2:0], 1'b1};
    end else begin
      rem_nxt = trial[DIV_BITS-1:0];
      quo_nxt = {quo_r[QUO_BITS-2:0], 1'b0};
    end
  end

  // products
  always_ff @(posedge clk) begin
    if (start) begin
      for (int i = 0; i < KERNEL_TAPS; i++) begin
        prod_r[i] <= coef[i] * $signed({1'b0, pix[i]});
      end
    end
  end

  // sum and division datapath
  always_ff @(posedge clk) begin
    if (prod_vld_r) begin
      sum_r <= sum_nxt;
    end
    if (sum_vld_r) begin
      quo_r <= sum_r[QUO_BITS-1:0];
      rem_r <= '0;
    end else if (div_busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  // sequence the lane and clamp the quotient
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
      sum_vld_r  <= 1'b0;
      div_busy_r <= 1'b0;
      cnt_r      <= '0;
      done_r     <= 1'b0;
      result_r   <= '0;
    end else begin
      prod_vld_r <= start;
      sum_vld_r  <= prod_vld_r;
      if (start) begin
        done_r <= 1'b0;
      end
      if (sum_vld_r) begin
        if (sum_r < 0) begin
          // negative sums clamp to zero without dividing
          result_r <= '0;
          done_r   <= 1'b1;
        end else begin
          div_busy_r <= 1'b1;
          cnt_r      <= CNT_BITS'(QUO_BITS);
        end
      end else if (div_busy_r) begin
        cnt_r <= cnt_r - CNT_BITS'(1);
        if (cnt_r == CNT_BITS'(1)) begin
          div_busy_r <= 1'b0;
          done_r     <= 1'b1;
          result_r   <= (quo_nxt > QUO_BITS'(255)) ? CHAN_BITS'(255)
                                                   : quo_nxt[CHAN_BITS-1:0];
        end
      end
    end
  end

  assign result      = result_r;
  assign status.busy = prod_vld_r | sum_vld_r | div_busy_r;
  assign status.done = done_r;

  // a result never shows while the lane still works
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !(prod_vld_r || sum_vld_r || div_busy_r))
    else $error("lane done while busy");
  // the divider counts down once per step
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (div_busy_r && cnt_r != CNT_BITS'(1)) |=> (div_busy_r && cnt_r == $past(cnt_r) - 1'b1))
    else $error("divider step lost");
  // a start pulse always reaches the sum stage, with done cleared
  a_start_done: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> ##1 (sum_vld_r && !done_r))
    else $error("lane sequence broken");

endmodule

// ===== tb/rkc_tb_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkc_tb_if
// Pulls in the stream interfaces for the testbench. The definitions
// themselves live with the RTL.
// ----------------------------------------------------------------------------
// The valid/ready interfaces rkc_in_if and rkc_out_if are compiled from
// rtl/core/rkc_if.sv, ahead of this file. The testbench instantiates them
// directly, so nothing is declared here.

// ===== tb/rgb_kernel_convolution_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_kernel_convolution_core_tb
// Self-checking bench for the streaming 3x3 RGB convolution core. Raster
// frames of several widths and kernel settings go in. Each filtered pixel
// is predicted and compared field by field as it comes out.
// ----------------------------------------------------------------------------
module rgb_kernel_convolution_core_tb;
  import rkc_pkg::*;

  localparam int                    MAX_W          = DEF_MAX_WIDTH;
  localparam int                    STALL_LIMIT    = 2000;
  localparam int                    SETTLE_CYCLES  = 40;
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED   = 3'd5;

  typedef struct {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [10:0] column;
    logic        row_end;
  } filt_px_t;

  // Predicts filtered pixels and holds the ones still due from the core.
  class conv_filter_sb;
    logic [ROW_BITS-1:0] kern [3];
    logic [DIV_BITS-1:0] div_reg;
    logic [FW_BITS-1:0]  width_reg;
    logic [PIX_BITS-1:0] line_mem [LINES][MAX_W];
    logic [PIX_BITS-1:0] win [3][3];
    int                  col_cnt;
    int                  row_cnt;
    filt_px_t            due_px [$];
    int                  errors;
    int                  pixels_in;
    int                  results_ok;

    function new();
      kern[0] = KERNEL_TOP_RST;
      kern[1] = KERNEL_MIDDLE_RST;
      kern[2] = KERNEL_BOTTOM_RST;
      div_reg = DIVISOR_RST;
      width_reg = FRAME_WIDTH_RST;
      foreach (line_mem[i, j]) line_mem[i][j] = '0;
      foreach (win[i, j]) win[i][j] = '0;
      col_cnt = 0;
      row_cnt = 0;
      errors = 0;
      pixels_in = 0;
      results_ok = 0;
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      errors++;
    endtask

    function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        REG_KERNEL_TOP:    kern[0] = data[ROW_BITS-1:0];
        REG_KERNEL_MIDDLE: kern[1] = data[ROW_BITS-1:0];
        REG_KERNEL_BOTTOM: kern[2] = data[ROW_BITS-1:0];
        REG_DIVISOR:       div_reg = data[DIV_BITS-1:0];
        REG_FRAME_WIDTH:   width_reg = data[FW_BITS-1:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] filter_chan(int sh);
      int         acc;
      int         dv;
      byte signed cf;
      acc = 0;
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++) begin
          cf = kern[r][c*COEF_BITS +: COEF_BITS];
          acc += int'(cf) * int'(win[r][c][sh +: 8]);
        end
      dv = (div_reg == 0) ? 1 : int'(div_reg);
      acc = acc / dv;
      if (acc < 0) return 8'd0;
      if (acc > 255) return 8'd255;
      return acc[7:0];
    endfunction

    // Advance the window and line stores by one pixel; queue a result
    // when the window sits fully inside the frame.
    function void take_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fs);
      int       w;
      int       col;
      filt_px_t px;
      pixels_in++;
      w = int'(width_reg);
      if (w < 3) w = 3;
      if (w > MAX_W) w = MAX_W;
      if (fs) begin
        col_cnt = 0;
        row_cnt = 0;
      end
      if (col_cnt >= w) col_cnt = 0;
      col = col_cnt;
      for (int i = 0; i < 3; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
      win[0][2] = line_mem[0][col];
      win[1][2] = line_mem[1][col];
      win[2][2] = {b, g, r};
      line_mem[0][col] = line_mem[1][col];
      line_mem[1][col] = {b, g, r};
      if (row_cnt >= LINES && col >= LINES) begin
        px.red = filter_chan(0);
        px.green = filter_chan(8);
        px.blue = filter_chan(16);
        px.column = 11'(col - LINES);
        px.row_end = (col + 1 == w);
        due_px = {due_px, px};
      end
      col_cnt = col + 1;
      if (col_cnt >= w) begin
        col_cnt = 0;
        if (row_cnt < LINES) row_cnt++;
      end
    endfunction

    task check_result(filt_px_t got);
      filt_px_t want;
      if (due_px.size() == 0) begin
        report($sformatf("unexpected filtered pixel at column %0d", got.column));
        return;
      end
      want = due_px.pop_front();
      if (got.red !== want.red)
        report($sformatf("red_out got %0d want %0d", got.red, want.red));
      if (got.green !== want.green)
        report($sformatf("green_out got %0d want %0d", got.green, want.green));
      if (got.blue !== want.blue)
        report($sformatf("blue_out got %0d want %0d", got.blue, want.blue));
      if (got.column !== want.column)
        report($sformatf("out_column got %0d want %0d", got.column, want.column));
      if (got.row_end !== want.row_end)
        report($sformatf("row_end got %0d want %0d", got.row_end, want.row_end));
      results_ok++;
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  bit                       idle_on;
  int                       quiet_cycles;
  int                       cur_width;
  conv_filter_sb            sb;

  rkc_in_if  pix_in ();
  rkc_out_if pix_out ();

  rgb_kernel_convolution_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pix    (pix_in.sink),
    .out_pix   (pix_out.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Track accepted transactions and register writes; run the watchdog.
  always @(posedge clk) begin
    filt_px_t got;
    bit       act;
    if (rst_n) begin
      act = 1'b0;
      if (cfg_we) begin
        sb.set_reg(cfg_index, cfg_data);
        act = 1'b1;
      end
      if (pix_in.valid && pix_in.ready) begin
        sb.take_pixel(pix_in.red_in, pix_in.green_in, pix_in.blue_in, pix_in.frame_start);
        act = 1'b1;
      end
      if (pix_out.valid && pix_out.ready) begin
        got.red = pix_out.red_out;
        got.green = pix_out.green_out;
        got.blue = pix_out.blue_out;
        got.column = pix_out.out_column;
        got.row_end = pix_out.row_end;
        sb.check_result(got);
        act = 1'b1;
      end
      quiet_cycles <= act ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("[rgb_kernel_convolution_core] ERROR");
        $finish;
      end
    end
  end

  // Result side back-pressure in random bursts.
  initial begin
    pix_out.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && rst_n && $urandom_range(0, 7) == 0) begin
        pix_out.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      pix_out.ready <= 1'b1;
    end
  end

  task write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold one pixel on the input until the core takes it.
  task send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fs);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      pix_in.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    pix_in.valid <= 1'b1;
    pix_in.red_in <= r;
    pix_in.green_in <= g;
    pix_in.blue_in <= b;
    pix_in.frame_start <= fs;
    do @(posedge clk); while (!pix_in.ready);
  endtask

  // Send rows of a frame; fill 0 is random, fill 1 is all 255.
  task send_frame(int rows, bit with_start, int fill);
    logic [7:0] r, g, b;
    for (int i = 0; i < rows * cur_width; i++) begin
      if (fill == 1) {r, g, b} = {3{8'hFF}};
      else {r, g, b} = {8'($urandom), 8'($urandom), 8'($urandom)};
      send_pixel(r, g, b, with_start && i == 0);
    end
  endtask

  // Drop valid and wait until every filtered pixel is back and the core is quiet.
  task drain();
    pix_in.valid <= 1'b0;
    while (sb.due_px.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task set_width(logic [FW_BITS-1:0] w);
    write_reg(REG_FRAME_WIDTH, CFG_DATA_BITS'(w));
    cur_width = (w < 3) ? 3 : (w > MAX_W) ? MAX_W : int'(w);
  endtask

  task random_setup();
    logic [DIV_BITS-1:0] dv;
    write_reg(REG_KERNEL_TOP, 24'($urandom));
    write_reg(REG_KERNEL_MIDDLE, 24'($urandom));
    write_reg(REG_KERNEL_BOTTOM, 24'($urandom));
    case ($urandom_range(0, 5))
      0: dv = 11'($urandom);
      1: dv = 11'd1;
      default: dv = 11'($urandom_range(1, 200));
    endcase
    write_reg(REG_DIVISOR, CFG_DATA_BITS'(dv));
    set_width(FW_BITS'($urandom_range(3, 12)));
  endtask

  initial begin
    sb = new();
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    idle_on = 1'b1;
    quiet_cycles = 0;
    cur_width = MAX_W;
    pix_in.valid = 1'b0;
    pix_in.red_in = '0;
    pix_in.green_in = '0;
    pix_in.blue_in = '0;
    pix_in.frame_start = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: largest positive kernel, zero divisor, width below minimum.
    write_reg(REG_KERNEL_TOP, 24'h7F7F7F);
    write_reg(REG_KERNEL_MIDDLE, 24'h7F7F7F);
    write_reg(REG_KERNEL_BOTTOM, 24'h7F7F7F);
    write_reg(REG_DIVISOR, '0);
    write_reg(REG_UNUSED, 24'hFFFFFF);
    set_width(12'd0);
    send_frame(3, 1'b1, 1);
    drain();

    // Directed: most negative kernel, largest divisor, then a row with no frame start.
    write_reg(REG_KERNEL_TOP, 24'h808080);
    write_reg(REG_KERNEL_MIDDLE, 24'h808080);
    write_reg(REG_KERNEL_BOTTOM, 24'h808080);
    write_reg(REG_DIVISOR, 24'd2047);
    set_width(12'd3);
    send_frame(3, 1'b1, 1);
    send_frame(1, 1'b0, 0);
    drain();

    // Random kernels, divisors and narrow widths.
    while (sb.pixels_in < 440) begin
      random_setup();
      send_frame($urandom_range(3, 6), 1'b1, 0);
      if ($urandom_range(0, 2) == 0) send_frame($urandom_range(1, 3), 1'b0, 0);
      if ($urandom_range(0, 3) == 0) send_frame($urandom_range(3, 4), 1'b1, 0);
      drain();
    end

    // Width register above the maximum: part of a first row at the clamped width.
    write_reg(REG_FRAME_WIDTH, 24'd2048);
    write_reg(REG_KERNEL_TOP, 24'h010101);
    write_reg(REG_KERNEL_MIDDLE, 24'h010801);
    write_reg(REG_KERNEL_BOTTOM, 24'h010101);
    write_reg(REG_DIVISOR, 24'd16);
    set_width(12'd4095);
    for (int i = 0; i < 96; i++) begin
      send_pixel(8'($urandom), 8'($urandom), 8'($urandom), i == 0);
    end
    drain();

    // Final stretch at full rate on both sides.
    idle_on = 1'b0;
    random_setup();
    send_frame(5, 1'b1, 0);
    drain();

    $display("covered %0d pixels and %0d filtered results", sb.pixels_in, sb.results_ok);
    $display("widths 3 to 12 plus a clamped 2048 row, extreme and random kernels, divisors 0 to 2047");
    if (sb.errors == 0) begin
      $display("[rgb_kernel_convolution_core] OK");
    end else begin
      $display("[rgb_kernel_convolution_core] ERROR");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/core/rkc_pkg.sv
rtl/core/rkc_if.sv
rtl/core/rkc_ram.sv
rtl/core/rkc_lane.sv
rtl/core/rgb_kernel_convolution_core.sv
tb/rkc_tb_if.sv
tb/rgb_kernel_convolution_core_tb.sv
